// ----- design/deq_pkg.sv -----
// Shared constants, types and ring-index helpers for the double-ended queue.
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int VALUE_W    = 32;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 5;
    localparam int IN_DATA_W  = ((VALUE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VALUE_W + POS_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST       = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic             re;
        logic [PTR_W-1:0] raddr;
    } store_req_t;

    // Ring index a + b, with a < DEPTH and b <= DEPTH
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
        if (s >= (CNT_W + 1)'(DEPTH))
        begin
            s = s - (CNT_W + 1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] a);
        logic [PTR_W-1:0] r;
        if (a == '0)
        begin
            r = PTR_W'(DEPTH - 1);
        end
        else
        begin
            r = a - PTR_W'(1);
        end
        return r;
    endfunction

endpackage

// ----- design/deq_store.sv -----
// Element store: single write port, single registered read port.
module deq_store (
    input  logic                        clk,
    input  deq_pkg::store_req_t         req,
    input  logic [deq_pkg::VALUE_W-1:0] wdata,
    output logic [deq_pkg::VALUE_W-1:0] rdata
);
    import deq_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= wdata;
        end
    end

    // Hold read data while the reader stalls
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/double_ended_queue.sv -----
// Top level of the bounded double-ended queue with ring storage.
//
//  channel | dir | tdata                          | tuser       | tlast
//  s_*     | in  | value[31:0]                    | opcode[2:0] | -
//  m_*     | out | element[31:0], position[36:32] | status[1:0] | last result
//
// Push and pop: the accept cycle updates the front pointer and count and issues the
// store access; EXEC then forms the result (pops use the read data) once output is free.
// List does one store read per element. No new item is accepted while in EXEC.
// Reset clears state, front pointer, count and output valid; store contents stay undefined.
// An output stall holds the sequencer in EXEC, which also freezes the store read register.
module double_ended_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [deq_pkg::IN_DATA_W-1:0]  s_tdata,   // value
    input  logic [deq_pkg::OP_W-1:0]       s_tuser,   // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [deq_pkg::OUT_DATA_W-1:0] m_tdata,   // element, position, zero pad
    output logic [deq_pkg::STATUS_W-1:0]   m_tuser,   // status
    output logic                           m_tlast
);
    import deq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    iter_reg, iter_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0] o_status_reg, o_status_next;
    logic [VALUE_W-1:0]  o_element_reg, o_element_next;
    logic [POS_W-1:0]    o_position_reg, o_position_next;
    logic                o_last_reg, o_last_next;

    store_req_t          store_req;
    logic [VALUE_W-1:0]  rdata;
    logic [VALUE_W-1:0]  value_in;
    logic                accept;
    logic                out_free;
    logic                full;
    logic                empty;
    logic                list_last;
    logic [31:0]         pos_wide;

    deq_store u_store (
        .clk   (clk),
        .req   (store_req),
        .wdata (value_in),
        .rdata (rdata)
    );

    assign value_in  = s_tdata[VALUE_W-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign list_last = ((CNT_W + 1)'(iter_reg) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(total_reg);
    assign pos_wide  = 32'(iter_reg) + 32'd1;

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        status_next     = status_reg;
        total_next      = total_reg;
        iter_next       = iter_reg;
        rd_ptr_next     = rd_ptr_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        o_status_next   = o_status_reg;
        o_element_next  = o_element_reg;
        o_position_next = o_position_reg;
        o_last_next     = o_last_reg;
        store_req       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = s_tuser;
                    status_next = STATUS_OK;
                    total_next  = count_reg;
                    iter_next   = '0;
                    rd_ptr_next = front_reg;
                    state_next  = ST_EXEC;
                    unique case (s_tuser)
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                front_next      = ring_dec(front_reg);
                                count_next      = count_reg + CNT_W'(1);
                                store_req.we    = 1'b1;
                                store_req.waddr = ring_dec(front_reg);
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                count_next      = count_reg + CNT_W'(1);
                                store_req.we    = 1'b1;
                                store_req.waddr = ring_add(front_reg, count_reg);
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                front_next      = ring_add(front_reg, CNT_W'(1));
                                count_next      = count_reg - CNT_W'(1);
                                store_req.re    = 1'b1;
                                store_req.raddr = front_reg;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next      = count_reg - CNT_W'(1);
                                store_req.re    = 1'b1;
                                store_req.raddr = ring_add(front_reg, count_reg - CNT_W'(1));
                            end
                        end
                        OP_LIST:
                        begin
                            if (empty)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                store_req.re    = 1'b1;
                                store_req.raddr = front_reg;
                            end
                        end
                        default:
                        begin
                            // drop undefined opcodes without a result
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    m_tvalid_next   = 1'b1;
                    o_status_next   = status_reg;
                    o_element_next  = '0;
                    o_position_next = '0;
                    o_last_next     = 1'b1;
                    state_next      = ST_IDLE;
                    if (status_reg == STATUS_OK)
                    begin
                        if (op_reg == OP_POP_FRONT || op_reg == OP_POP_BACK)
                        begin
                            o_element_next = rdata;
                        end
                        else if (op_reg == OP_LIST)
                        begin
                            o_element_next  = rdata;
                            o_position_next = pos_wide[POS_W-1:0];
                            o_last_next     = list_last;
                            if (!list_last)
                            begin
                                // advance to the next element
                                store_req.re    = 1'b1;
                                store_req.raddr = ring_add(rd_ptr_reg, CNT_W'(1));
                                rd_ptr_next     = ring_add(rd_ptr_reg, CNT_W'(1));
                                iter_next       = iter_reg + CNT_W'(1);
                                state_next      = ST_EXEC;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            front_reg    <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        status_reg     <= status_next;
        total_reg      <= total_next;
        iter_reg       <= iter_next;
        rd_ptr_reg     <= rd_ptr_next;
        o_status_reg   <= o_status_next;
        o_element_reg  <= o_element_next;
        o_position_reg <= o_position_next;
        o_last_reg     <= o_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = o_status_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = OUT_DATA_W'({o_position_reg, o_element_reg});

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above capacity");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg < PTR_W'(DEPTH - 1) || front_reg == PTR_W'(DEPTH - 1))
        else $error("front pointer outside the ring");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !full && (s_tuser == OP_PUSH_FRONT || s_tuser == OP_PUSH_BACK)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted push did not grow the queue");

    a_list_iter: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC && op_reg == OP_LIST && status_reg == STATUS_OK
        |-> iter_reg < total_reg)
        else $error("list walk ran past the element count");

    a_store_order: assert property (@(posedge clk) disable iff (!rst_n)
        store_req.we |-> state_reg == ST_IDLE && !store_req.re)
        else $error("store write overlaps a read");

endmodule

// ----- tb/sv/tb_double_ended_queue.sv -----
// Self-checking testbench for double_ended_queue: directed edge cases, then random deque traffic.
module tb_double_ended_queue;

    import deq_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;
    localparam int              CYCLE_LIMIT       = 400000;
    localparam int              ITEMS_PER_PHASE   = 100;
    localparam int              TAIL_CYCLES       = 32;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  element;
        logic [POS_W-1:0]    position;
        logic                last;
    } deq_result_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [OP_W-1:0]       s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;

    // Shadow copy of the deque contents
    logic [VALUE_W-1:0] shadow_store [DEPTH];
    int                 shadow_front = 0;
    int                 shadow_count = 0;
    deq_result_t        pending_results [$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    bit filling_up      = 1'b1;
    int mismatch_count  = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int full_answers    = 0;
    int empty_answers   = 0;
    int lists_nonempty  = 0;
    int cycle_count     = 0;

    double_ended_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run timed out with %0d results outstanding", $time,
                     pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Apply one accepted operation to the shadow deque and queue its results
    function automatic void deque_apply(input logic [OP_W-1:0] op,
                                        input logic [VALUE_W-1:0] val);
        deq_result_t r;
        int          idx;
        r = '{status: STATUS_OK, element: '0, position: '0, last: 1'b1};
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (shadow_count >= DEPTH)
                begin
                    r.status = STATUS_FULL;
                    full_answers++;
                end
                else
                begin
                    if (op == OP_PUSH_FRONT)
                    begin
                        shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                        shadow_store[shadow_front] = val;
                    end
                    else
                    begin
                        shadow_store[(shadow_front + shadow_count) % DEPTH] = val;
                    end
                    shadow_count++;
                end
                pending_results.push_back(r);
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (shadow_count == 0)
                begin
                    r.status = STATUS_EMPTY;
                    empty_answers++;
                end
                else
                begin
                    if (op == OP_POP_FRONT)
                    begin
                        idx = shadow_front;
                        shadow_front = (shadow_front + 1) % DEPTH;
                    end
                    else
                    begin
                        idx = (shadow_front + shadow_count - 1) % DEPTH;
                    end
                    shadow_count--;
                    r.element = shadow_store[idx];
                end
                pending_results.push_back(r);
            end
            OP_LIST:
            begin
                if (shadow_count == 0)
                begin
                    r.status = STATUS_EMPTY;
                    empty_answers++;
                    pending_results.push_back(r);
                end
                else
                begin
                    lists_nonempty++;
                    for (int i = 0; i < shadow_count; i++)
                    begin
                        r.element  = shadow_store[(shadow_front + i) % DEPTH];
                        r.position = POS_W'(i + 1);
                        r.last     = (i + 1 == shadow_count);
                        pending_results.push_back(r);
                    end
                end
            end
            default:
            begin
                // reserved opcodes produce nothing
            end
        endcase
    endfunction

    // Drive one item and hold it until the transfer completes
    task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        deque_apply(op, val);
    endtask

    // Idle the sender and wait until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(7))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = '0;
            3:       v = '1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Receiver: randomized backpressure, check every transfer against the oldest expectation
    always @(posedge clk)
    begin : result_check
        deq_result_t want;
        deq_result_t got;
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status   = m_tuser;
            got.element  = m_tdata[VALUE_W-1:0];
            got.position = m_tdata[VALUE_W+POS_W-1:VALUE_W];
            got.last     = m_tlast;
            results_checked++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result status %0d element %0d position %0d last %0d",
                         $time, got.status, $signed(got.element), got.position, got.last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.element !== want.element ||
                    got.position !== want.position || got.last !== want.last)
                begin
                    mismatch_count++;
                    $display("%0t: expected status %0d element %0d position %0d last %0d",
                             $time, want.status, $signed(want.element), want.position,
                             want.last);
                    $display("%0t:   actual status %0d element %0d position %0d last %0d",
                             $time, got.status, $signed(got.element), got.position,
                             got.last);
                end
            end
        end
    end

    task automatic test_empty_queue();
        send_item(OP_POP_FRONT, 32'h7FFF_FFFF);
        send_item(OP_POP_BACK, 32'h8000_0000);
        send_item(OP_LIST, '1);
        for (int op = OP_RESERVED_FIRST; op <= OP_RESERVED_LAST; op++)
        begin
            send_item(OP_W'(op), $urandom);
        end
        wait_drained();
    endtask

    // Fill from both ends with extreme values, overflow at each end, then list all
    task automatic test_fill_to_full();
        logic [VALUE_W-1:0] v;
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i)
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2:       v = '0;
                3:       v = '1;
                4:       v = 32'hAAAA_AAAA;
                5:       v = 32'h5555_5555;
                default: v = $urandom;
            endcase
            send_item((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, v);
        end
        send_item(OP_PUSH_FRONT, 32'h1234_5678);
        send_item(OP_PUSH_BACK, 32'h8765_4321);
        send_item(OP_LIST, '0);
        wait_drained();
    endtask

    // Random walk between full and empty; reserved opcodes do not count as items
    task automatic run_random(input int n);
        int              counted;
        int              roll;
        logic [OP_W-1:0] op;
        counted = 0;
        while (counted < n)
        begin
            if (shadow_count >= DEPTH)
            begin
                filling_up = 1'b0;
            end
            else if (shadow_count == 0)
            begin
                filling_up = 1'b1;
            end
            else if ($urandom_range(99) < 3)
            begin
                filling_up = !filling_up;
            end
            roll = $urandom_range(99);
            if (roll < 3)
            begin
                op = OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
            end
            else
            begin
                counted++;
                if (roll < 13)
                begin
                    op = OP_LIST;
                end
                else if (($urandom_range(99) < 75) == filling_up)
                begin
                    op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                end
                else
                begin
                    op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
                end
            end
            send_item(op, pick_value());
        end
        wait_drained();
    endtask

    task automatic test_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(ITEMS_PER_PHASE);
    endtask

    task automatic test_sender_idle();
        send_idle_pct  = 85;
        recv_stall_pct = 0;
        run_random(ITEMS_PER_PHASE);
    endtask

    task automatic test_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 85;
        run_random(ITEMS_PER_PHASE);
    endtask

    task automatic test_both_idle();
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        run_random(ITEMS_PER_PHASE);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_fill_to_full();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();

        wait_drained();
        // catch any stray result after the last expected one
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d operations and %0d results under four idle/stall mixes.",
                 items_sent, results_checked);
        $display("Full answers %0d, empty answers %0d, non-empty lists %0d.",
                 full_answers, empty_answers, lists_nonempty);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
